### rtl/assert_macros.svh
// Assertion macros used by the classifier top level.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/ucc_pkg.sv
// Types and constants of the UTF-8 character classifier.
// No dependencies.
package ucc_pkg;

	typedef enum logic [3:0] {
		CLS_SPACE   = 4'd0,
		CLS_IPUNCT  = 4'd1,
		CLS_SYMBOL  = 4'd2,
		CLS_HIRA    = 4'd3,
		CLS_KATA    = 4'd4,
		CLS_HKANA   = 4'd5,
		CLS_MDOT    = 4'd6,
		CLS_COMMA   = 4'd7,
		CLS_SLASH   = 4'd8,
		CLS_COLON   = 4'd9,
		CLS_PERIOD  = 4'd10,
		CLS_FIGURE  = 4'd11,
		CLS_KFIG    = 4'd12,
		CLS_ALPHA   = 4'd13,
		CLS_KANJI   = 4'd14,
		CLS_BRACKET = 4'd15
	} cls_t;

	// Range and equality hits, one per test, in priority order.
	typedef struct packed {
		logic space;
		logic ipunct;
		logic era;
		logic hira;
		logic kata;
		logic kata_lv;
		logic hkana;
		logic hkana_lv;
		logic mdot;
		logic comma;
		logic slash;
		logic colon;
		logic period;
		logic figure;
		logic kfig;
		logic kfig_digit;
		logic kfig_word;
		logic alpha;
		logic kanji;
		logic bracket;
	} hits_t;

	typedef struct packed {
		logic era;
		logic long_vowel;
		logic numeral_digit;
		logic numeral_word;
	} flags_t;

	localparam int BRACKET_N = 120;

	localparam logic [15:0] BRACKET_TAB [BRACKET_N] = '{
		16'h0028, 16'h0029, 16'h005B, 16'h005D, 16'h007B, 16'h007D,
		16'h0F3A, 16'h0F3B, 16'h0F3C, 16'h0F3D, 16'h169B, 16'h169C,
		16'h2045, 16'h2046, 16'h207D, 16'h207E, 16'h208D, 16'h208E,
		16'h2308, 16'h2309, 16'h230A, 16'h230B, 16'h2329, 16'h232A,
		16'h2768, 16'h2769, 16'h276A, 16'h276B, 16'h276C, 16'h276D, 16'h276E, 16'h276F,
		16'h2770, 16'h2771, 16'h2772, 16'h2773, 16'h2774, 16'h2775,
		16'h27C5, 16'h27C6,
		16'h27E6, 16'h27E7, 16'h27E8, 16'h27E9, 16'h27EA, 16'h27EB, 16'h27EC, 16'h27ED,
		16'h27EE, 16'h27EF,
		16'h2983, 16'h2984, 16'h2985, 16'h2986, 16'h2987, 16'h2988, 16'h2989, 16'h298A,
		16'h298B, 16'h298C, 16'h298D, 16'h2990, 16'h298F, 16'h298E, 16'h2991, 16'h2992,
		16'h2993, 16'h2994, 16'h2995, 16'h2996, 16'h2997, 16'h2998,
		16'h29D8, 16'h29D9, 16'h29DA, 16'h29DB, 16'h29FC, 16'h29FD,
		16'h2E22, 16'h2E23, 16'h2E24, 16'h2E25, 16'h2E26, 16'h2E27, 16'h2E28, 16'h2E29,
		16'h3008, 16'h3009, 16'h300A, 16'h300B, 16'h300C, 16'h300D, 16'h300E, 16'h300F,
		16'h3010, 16'h3011, 16'h3014, 16'h3015, 16'h3016, 16'h3017, 16'h3018, 16'h3019,
		16'h301A, 16'h301B,
		16'hFE59, 16'hFE5A, 16'hFE5B, 16'hFE5C, 16'hFE5D, 16'hFE5E,
		16'hFF08, 16'hFF09, 16'hFF3B, 16'hFF3D, 16'hFF5B, 16'hFF5D, 16'hFF5F, 16'hFF60,
		16'hFF62, 16'hFF63
	};

endpackage

### rtl/ucc_channels.sv
// Valid/ready channel interfaces: character bytes in, classification out.
// No package dependencies.
interface ucc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] lead_byte;
	logic [7:0] second_byte;
	logic [7:0] third_byte;

	modport source (output valid, lead_byte, second_byte, third_byte, input ready);
	modport sink (input valid, lead_byte, second_byte, third_byte, output ready);
endinterface

interface ucc_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_point;
	logic [3:0]  char_class;
	logic        era_mark;
	logic        long_vowel_mark;
	logic        numeral_digit_mark;
	logic        numeral_word_mark;

	modport source (output valid, code_point, char_class, era_mark, long_vowel_mark,
		numeral_digit_mark, numeral_word_mark, input ready);
	modport sink (input valid, code_point, char_class, era_mark, long_vowel_mark,
		numeral_digit_mark, numeral_word_mark, output ready);
endinterface

### rtl/utf8_char_classifier_top.sv
// Top level of the UTF-8 character classifier: three-stage pipeline.
// Depends on ucc_pkg, ucc_channels, ucc_decode, ucc_match, ucc_prio, assert_macros.svh.
//
//  channel  direction  payload
//  text     in         lead_byte, second_byte, third_byte
//  result   out        code_point, char_class, four mark bits
//
// One beat per cycle while result is ready; a beat passes the s1, s2, s3 registers.
// Stage 1 decodes, stage 2 runs the range and bracket table compares,
// stage 3 holds the resolved class and drives the result channel.
// Reset clears the stage valid bits only; nothing else needs clearing.
// A stall on result backs up stage by stage; a stage moves when the next one is
// empty or moving, so no beat is dropped or repeated.
`include "assert_macros.svh"

module utf8_char_classifier_top
	import ucc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	ucc_char_if.sink     text,
	ucc_result_if.source result
);

	logic        v_s1, v_s2, v_s3;
	logic        rdy_s1, rdy_s2, rdy_s3;
	logic [15:0] code_s1, code_s2, code_s3;
	hits_t       hits_s2;
	cls_t        class_s3;
	flags_t      flags_s3;

	logic [15:0] code_dec;
	hits_t       hits_cmb;
	cls_t        class_cmb;
	flags_t      flags_cmb;

	assign rdy_s3     = !v_s3 || result.ready;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign text.ready = rdy_s1;

	ucc_decode u_decode (
		.lead_byte  (text.lead_byte),
		.second_byte(text.second_byte),
		.third_byte (text.third_byte),
		.code_point (code_dec)
	);

	ucc_match u_match (
		.code_point(code_s1),
		.hits      (hits_cmb)
	);

	ucc_prio u_prio (
		.hits      (hits_s2),
		.char_class(class_cmb),
		.flags     (flags_cmb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= text.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && text.valid) begin
			code_s1 <= code_dec;
		end
		if (rdy_s2 && v_s1) begin
			code_s2 <= code_s1;
			hits_s2 <= hits_cmb;
		end
		if (rdy_s3 && v_s2) begin
			code_s3  <= code_s2;
			class_s3 <= class_cmb;
			flags_s3 <= flags_cmb;
		end
	end

	assign result.valid              = v_s3;
	assign result.code_point         = code_s3;
	assign result.char_class         = class_s3;
	assign result.era_mark           = flags_s3.era;
	assign result.long_vowel_mark    = flags_s3.long_vowel;
	assign result.numeral_digit_mark = flags_s3.numeral_digit;
	assign result.numeral_word_mark  = flags_s3.numeral_word;

	`ASSERT_IMPL(a_one_flag, v_s3, $onehot0(flags_s3), "more than one mark set")
	`ASSERT_IMPL(a_era_symbol, v_s3 && flags_s3.era, class_s3 == CLS_SYMBOL, "era mark off symbol")
	`ASSERT_IMPL(a_zero_symbol, v_s3 && code_s3 == 16'h0000,
		class_s3 == CLS_SYMBOL && flags_s3 == '0, "code 0 not plain symbol")
	`ASSERT_NEXT(a_s1_hold, v_s1 && !rdy_s2, v_s1 && $stable(code_s1), "stage 1 lost on stall")
	`ASSERT_NEXT(a_s2_hold, v_s2 && !rdy_s3, v_s2 && $stable(hits_s2), "stage 2 lost on stall")

endmodule

### rtl/ucc_decode.sv
// UTF-8 decode of up to three bytes into a 16-bit code point.
// No package dependencies.
module ucc_decode (
	input  logic [7:0]  lead_byte,
	input  logic [7:0]  second_byte,
	input  logic [7:0]  third_byte,
	output logic [15:0] code_point
);

	always_comb begin
		if (lead_byte > 8'hEF) begin
			// four-byte lead is not decoded
			code_point = 16'h0000;
		end else if (lead_byte > 8'hDF) begin
			code_point = {lead_byte[3:0], second_byte[5:0], third_byte[5:0]};
		end else if (lead_byte > 8'h7F) begin
			code_point = {5'b0, lead_byte[4:0], second_byte[5:0]};
		end else begin
			code_point = {8'h00, lead_byte};
		end
	end

endmodule

### rtl/ucc_match.sv
// Range, equality and bracket table compares on one code point.
// Depends on ucc_pkg (hits_t, BRACKET_TAB).
module ucc_match
	import ucc_pkg::*;
(
	input  logic [15:0] code_point,
	output hits_t       hits
);

	logic bracket_hit;

	always_comb begin
		bracket_hit = 1'b0;
		for (int i = 0; i < BRACKET_N; i++) begin
			if (code_point == BRACKET_TAB[i]) begin
				bracket_hit = 1'b1;
			end
		end
	end

	always_comb begin
		hits.space      = code_point inside {16'h0020, 16'h3000, 16'h00A0, 16'h1680,
			16'h180E, [16'h2000:16'h200B], 16'h202F, 16'h205F, 16'hFEFF};
		hits.ipunct     = code_point inside {[16'h3001:16'h3002]};
		hits.era        = code_point inside {[16'h337B:16'h337E]};
		hits.hira       = code_point inside {[16'h3040:16'h309F]};
		hits.kata       = code_point inside {[16'h30A0:16'h30FA]};
		hits.kata_lv    = (code_point == 16'h30FC);
		hits.hkana      = code_point inside {[16'h00A1:16'h00DF]};
		hits.hkana_lv   = (code_point == 16'hFF70);
		hits.mdot       = code_point inside {16'h00B7, 16'h30FB};
		hits.comma      = code_point inside {16'h002C, 16'hFF0C};
		hits.slash      = code_point inside {16'h002F, 16'hFF0F};
		hits.colon      = code_point inside {16'h003A, 16'hFF1A};
		hits.period     = (code_point == 16'hFF0E);
		hits.figure     = code_point inside {[16'h0030:16'h0039], [16'hFF10:16'hFF19]};
		hits.kfig       = code_point inside {16'h25CB, 16'h3007, 16'h96F6, 16'h4E00,
			16'h4E8C, 16'h4E09, 16'h56DB, 16'h4E94, 16'h516D, 16'h4E03, 16'h516B, 16'h4E5D};
		hits.kfig_digit = code_point inside {16'h5341, 16'h767E, 16'h5343, 16'h4E07,
			16'h5104, 16'h5146};
		hits.kfig_word  = code_point inside {16'h6570, 16'h4F55, 16'h5E7E};
		hits.alpha      = code_point inside {[16'h0041:16'h005A], [16'h0061:16'h007A],
			[16'h00C0:16'h00FF], [16'hFF21:16'hFF3A], [16'hFF41:16'hFF5A]};
		hits.kanji      = code_point inside {[16'h4E00:16'h9FFF], 16'h3005, 16'h3007};
		hits.bracket    = bracket_hit;
	end

endmodule

### rtl/ucc_prio.sv
// Priority resolve of the hit vector into class and modifier flags.
// Depends on ucc_pkg (hits_t, cls_t, flags_t).
module ucc_prio
	import ucc_pkg::*;
(
	input  hits_t  hits,
	output cls_t   char_class,
	output flags_t flags
);

	always_comb begin
		flags      = '0;
		char_class = CLS_SYMBOL;
		if (hits.space) begin
			char_class = CLS_SPACE;
		end else if (hits.ipunct) begin
			char_class = CLS_IPUNCT;
		end else if (hits.era) begin
			char_class = CLS_SYMBOL;
			flags.era  = 1'b1;
		end else if (hits.hira) begin
			char_class = CLS_HIRA;
		end else if (hits.kata) begin
			char_class = CLS_KATA;
		end else if (hits.kata_lv) begin
			char_class       = CLS_KATA;
			flags.long_vowel = 1'b1;
		end else if (hits.hkana) begin
			char_class = CLS_HKANA;
		end else if (hits.hkana_lv) begin
			char_class       = CLS_HKANA;
			flags.long_vowel = 1'b1;
		end else if (hits.mdot) begin
			char_class = CLS_MDOT;
		end else if (hits.comma) begin
			char_class = CLS_COMMA;
		end else if (hits.slash) begin
			char_class = CLS_SLASH;
		end else if (hits.colon) begin
			char_class = CLS_COLON;
		end else if (hits.period) begin
			char_class = CLS_PERIOD;
		end else if (hits.figure) begin
			char_class = CLS_FIGURE;
		end else if (hits.kfig) begin
			char_class = CLS_KFIG;
		end else if (hits.kfig_digit) begin
			char_class          = CLS_KFIG;
			flags.numeral_digit = 1'b1;
		end else if (hits.kfig_word) begin
			char_class         = CLS_KFIG;
			flags.numeral_word = 1'b1;
		end else if (hits.alpha) begin
			char_class = CLS_ALPHA;
		end else if (hits.kanji) begin
			char_class = CLS_KANJI;
		end else if (hits.bracket) begin
			char_class = CLS_BRACKET;
		end
	end

endmodule
